// ----- rtl/dtoi_pkg.sv -----
`default_nettype none

package dtoi_pkg;

   // Default for the longest digit run that still counts as in range.
   localparam int unsigned MAX_DIGITS_DEF = 10;

   // Character codes the scanner looks for.
   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   // Largest magnitudes for a positive and a negative result.
   localparam logic [32:0] MAG_LIMIT_POS = 33'd2147483647;
   localparam logic [32:0] MAG_LIMIT_NEG = 33'd2147483648;

   // Scan phase of the current string.
   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_IGNORE = 2'd3
   } phase_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_NONE  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   // One input item: a single byte of the string.
   typedef struct packed {
      logic [7:0] char_code;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [31:0] value;
      status_type         status;
   } rsp_type;

   // Whitespace set: space, backspace, tab, newline, vertical tab, form feed, return.
   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'd32) || ((c >= 8'd8) && (c <= 8'd13));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/dtoi_if.sv -----
`default_nettype none

// Valid/ready channel carrying one item of data_type.
interface dtoi_if #(
   parameter type data_type = logic [7:0]
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtoi_in_reg.sv -----
`default_nettype none

module dtoi_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   dtoi_if.sink                   req,
   input  wire logic              take,
   output logic                   char_valid_ff,
   output logic [7:0]             char_code_ff
);
   import dtoi_pkg::*;

   logic       char_valid_in;
   logic [7:0] char_code_in;

   // The register frees up whenever the scanner takes its item.
   assign req.ready = !char_valid_ff || take;

   always_comb begin
      char_valid_in = char_valid_ff;
      char_code_in  = char_code_ff;
      if (req.ready) begin
         char_valid_in = req.valid;
         char_code_in  = req.data.char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_valid_ff <= 1'b0;
      end else begin
         char_valid_ff <= char_valid_in;
      end
      char_code_ff <= char_code_in;
   end

endmodule

`default_nettype wire

// ----- rtl/dtoi_scan.sv -----
`default_nettype none

module dtoi_scan #(
   parameter int unsigned MAX_DIGITS = dtoi_pkg::MAX_DIGITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              char_valid,
   input  wire logic [7:0]        char_code,
   input  wire logic              out_free,
   output logic                   take,
   output logic                   res_load,
   output dtoi_pkg::rsp_type      res
);
   import dtoi_pkg::*;

   // Bits for MAX_DIGITS decimal digits (log2 of 10 is about 3.322).
   localparam int unsigned MagW = (MAX_DIGITS * 3322) / 1000 + 1;
   localparam int unsigned CmpW = (MagW > 33) ? MagW : 33;
   localparam int unsigned CntW = $clog2(MAX_DIGITS + 2);
   localparam logic [CntW-1:0] CntMax = CntW'(MAX_DIGITS);

   phase_type       phase_ff, phase_in;
   logic            negative_ff, negative_in;
   logic [MagW-1:0] magnitude_ff, magnitude_in;
   logic [CntW-1:0] digit_count_ff, digit_count_in;

   logic            is_nul;
   logic [CmpW-1:0] mag_ext;
   logic [CmpW-1:0] limit;
   logic [MagW-1:0] mag_times_ten;

   // A NUL needs room in the output register; other characters never wait.
   assign is_nul   = (char_code == CHAR_NUL);
   assign take     = char_valid && (!is_nul || out_free);
   assign res_load = take && is_nul;

   // Times ten as two shifts and an add, then the new digit.
   assign mag_times_ten = (magnitude_ff << 3) + (magnitude_ff << 1)
                        + MagW'(char_code[3:0]);

   // Result formed from the state that the string left behind.
   assign mag_ext = CmpW'(magnitude_ff);
   assign limit   = negative_ff ? CmpW'(MAG_LIMIT_NEG) : CmpW'(MAG_LIMIT_POS);

   always_comb begin
      res.value  = '0;
      res.status = STAT_OK;
      if (digit_count_ff == '0) begin
         res.status = STAT_NONE;
      end else if ((digit_count_ff > CntMax) || (mag_ext > limit)) begin
         res.status = STAT_RANGE;
      end else if (negative_ff) begin
         res.value = 32'd0 - mag_ext[31:0];
      end else begin
         res.value = mag_ext[31:0];
      end
   end

   // Phase and accumulator update for one character.
   always_comb begin
      phase_in       = phase_ff;
      negative_in    = negative_ff;
      magnitude_in   = magnitude_ff;
      digit_count_in = digit_count_ff;
      if (take) begin
         if (is_nul) begin
            phase_in       = PH_SPACE;
            negative_in    = 1'b0;
            magnitude_in   = '0;
            digit_count_in = '0;
         end else begin
            unique case (phase_ff)
               PH_SPACE, PH_SIGN, PH_DIGITS: begin
                  if (is_digit(char_code)) begin
                     phase_in = PH_DIGITS;
                     if (digit_count_ff <= CntMax) begin
                        digit_count_in = digit_count_ff + 1'b1;
                        if (digit_count_ff < CntMax) begin
                           magnitude_in = mag_times_ten;
                        end
                     end
                  end else if ((phase_ff == PH_SPACE) && is_space(char_code)) begin
                     phase_in = PH_SPACE;
                  end else if ((phase_ff == PH_SPACE) &&
                               ((char_code == CHAR_PLUS) || (char_code == CHAR_MINUS))) begin
                     phase_in    = PH_SIGN;
                     negative_in = (char_code == CHAR_MINUS);
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_IGNORE: begin
                  phase_in = PH_IGNORE;
               end
               default: begin
                  phase_in = PH_IGNORE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SPACE;
         negative_ff    <= 1'b0;
         magnitude_ff   <= '0;
         digit_count_ff <= '0;
      end else begin
         phase_ff       <= phase_in;
         negative_ff    <= negative_in;
         magnitude_ff   <= magnitude_in;
         digit_count_ff <= digit_count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dtoi_out_reg.sv -----
`default_nettype none

module dtoi_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire dtoi_pkg::rsp_type res,
   output logic                   out_free,
   dtoi_if.source                 rsp
);
   import dtoi_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // The register can take a new item when empty or being emptied now.
   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff && !rsp.ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/decimal_text_to_int32_parser.sv -----
// A NUL passes the input register; its result is then registered in the result register and offered from there.
// Throughput: one character per cycle while no NUL waits for the result register.
// A NUL waits in the input register only while the result register is full.
// Reset (synchronous, active high) empties both registers and restarts the scan.
`default_nettype none

module decimal_text_to_int32_parser #(
   parameter int unsigned MAX_DIGITS = dtoi_pkg::MAX_DIGITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   dtoi_if.sink      req_if,
   dtoi_if.source    rsp_if
);
   import dtoi_pkg::*;

   logic       char_valid_ff;
   logic [7:0] char_code_ff;
   logic       take;
   logic       res_load;
   logic       out_free;
   rsp_type    res;

   // Input register.
   dtoi_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .take          (take),
      .char_valid_ff (char_valid_ff),
      .char_code_ff  (char_code_ff)
   );

   // Character scanner and result forming.
   dtoi_scan #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .char_valid (char_valid_ff),
      .char_code  (char_code_ff),
      .out_free   (out_free),
      .take       (take),
      .res_load   (res_load),
      .res        (res)
   );

   // Result register.
   dtoi_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (res_load),
      .res      (res),
      .out_free (out_free),
      .rsp      (rsp_if)
   );

   // Results are made only from a NUL.
   assert property (@(posedge clock) disable iff (reset)
      res_load |-> (char_valid_ff && (char_code_ff == CHAR_NUL)))
      else $error("result loaded from a character that is not NUL");

   // A loaded result is offered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      res_load |=> rsp_if.valid)
      else $error("loaded result not offered");

   // An accepted item never overwrites one the scanner has not taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> (!char_valid_ff || take))
      else $error("input register overwritten");

   // Failed parses carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.data.status != STAT_OK)) |-> (rsp_if.data.value == 32'sd0))
      else $error("nonzero value with failure status");

endmodule

`default_nettype wire

// ----- tb/decimal_text_to_int32_parser_tb.sv -----
`default_nettype none

module decimal_text_to_int32_parser_tb;
   import dtoi_pkg::*;

   localparam int unsigned DIGIT_LIMIT = MAX_DIGITS_DEF;
   localparam int unsigned RANDOM_CHARS = 510;

   logic clock;
   logic reset;

   dtoi_if #(.data_type(req_type)) req_ch ();
   dtoi_if #(.data_type(rsp_type)) rsp_ch ();

   decimal_text_to_int32_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Characters still to be sent, and parse results still to arrive.
   logic [7:0] pending_chars[$];
   rsp_type    expected_results[$];
   int         drain_points[$];
   int         chars_sent = 0;
   int         failures = 0;
   bit         item_taken = 1'b0;

   // Scanner state kept by the predictor.
   phase_type   scan_phase = PH_SPACE;
   logic        scan_negative = 1'b0;
   logic [33:0] scan_magnitude = '0;
   logic [3:0]  scan_digits = '0;

   logic [7:0]      blank_codes [0:6] = '{8'd32, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
   longint unsigned boundary_values [0:7] = '{64'd2147483646, 64'd2147483647,
      64'd2147483648, 64'd2147483649, 64'd0, 64'd4294967295, 64'd9999999999,
      64'd1000000000};

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Accumulate one digit; the magnitude freezes once the digit run is too long.
   function automatic void take_digit(input logic [7:0] c);
      if (scan_digits < DIGIT_LIMIT + 1) begin
         scan_digits = scan_digits + 4'd1;
         if (scan_digits <= DIGIT_LIMIT)
            scan_magnitude = scan_magnitude * 34'd10 + 34'(c - CHAR_ZERO);
      end
      scan_phase = PH_DIGITS;
   endfunction

   // Advance the scanner by one character; returns 1 when a NUL closes the string.
   function automatic bit scan_char(input logic [7:0] c, output rsp_type res);
      logic [32:0] limit;
      logic        blank;
      res = '0;
      if (c == CHAR_NUL) begin
         limit = scan_negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS;
         if (scan_digits == 4'd0) begin
            res.status = STAT_NONE;
         end else if (scan_digits > DIGIT_LIMIT || scan_magnitude > {1'b0, limit}) begin
            res.status = STAT_RANGE;
         end else begin
            res.status = STAT_OK;
            res.value = scan_negative ? -scan_magnitude[31:0] : scan_magnitude[31:0];
         end
         scan_phase = PH_SPACE;
         scan_negative = 1'b0;
         scan_magnitude = '0;
         scan_digits = '0;
         return 1'b1;
      end
      blank = (c == 8'd32) || (c == 8'd8) || (c == 8'd9) || (c == 8'd10) ||
              (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
      case (scan_phase)
         PH_SPACE: begin
            if (blank) begin
               // Leading whitespace is skipped.
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               scan_negative = (c == CHAR_MINUS);
               scan_phase = PH_SIGN;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               take_digit(c);
            end else begin
               scan_phase = PH_IGNORE;
            end
         end
         PH_SIGN, PH_DIGITS: begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
               take_digit(c);
            else
               scan_phase = PH_IGNORE;
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   // Queue a text followed by its NUL terminator.
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         pending_chars.push_back(s[i]);
      pending_chars.push_back(CHAR_NUL);
   endtask

   // Queue the decimal digits of a number, without a terminator.
   task automatic add_number(input longint unsigned num);
      logic [7:0] digs[$];
      do begin
         digs.push_front(CHAR_ZERO + 8'(num % 10));
         num = num / 10;
      end while (num != 0);
      foreach (digs[i])
         pending_chars.push_back(digs[i]);
   endtask

   // Queue one random string: mostly well formed numbers, some pure noise.
   task automatic add_random_string();
      int ndig;
      if ($urandom_range(0, 9) < 7) begin
         repeat ($urandom_range(0, 3))
            pending_chars.push_back(blank_codes[$urandom_range(0, 6)]);
         case ($urandom_range(0, 2))
            1: pending_chars.push_back(CHAR_PLUS);
            2: pending_chars.push_back(CHAR_MINUS);
            default: begin
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 2))
               pending_chars.push_back(CHAR_ZERO);
            add_number(boundary_values[$urandom_range(0, 7)]);
         end else begin
            ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 9);
            repeat (ndig)
               pending_chars.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 4))
               pending_chars.push_back(8'($urandom_range(1, 255)));
         end
      end else begin
         if ($urandom_range(0, 1) == 0)
            pending_chars.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
         repeat ($urandom_range(0, 6))
            pending_chars.push_back(8'($urandom_range(1, 255)));
      end
      pending_chars.push_back(CHAR_NUL);
   endtask

   // Report a bad result; only the first few are printed.
   task automatic log_failure(input string what, input rsp_type want, input rsp_type got);
      failures++;
      if (failures <= 10)
         $display("%s: expected value %0d status %0d, got value %0d status %0d",
                  what, want.value, want.status, got.value, got.status);
   endtask

   // Sample both handshakes at the rising edge and check results in order.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      item_taken = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_results.size() == 0) begin
               log_failure("Unexpected result", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.value !== want.value || got.status !== want.status)
                  log_failure("Result mismatch", want, got);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            item_taken = 1'b1;
            if (scan_char(req_ch.data.char_code, want))
               expected_results.push_back(want);
         end
      end
   end

   // Character driver: bursts with random gaps, plus pauses that wait for all results.
   always @(negedge clock) begin : driver
      logic       drive_valid;
      logic [7:0] drive_char;
      int         burst_left;
      int         gap_left;
      drive_valid = req_ch.valid;
      drive_char = req_ch.data.char_code;
      if (reset) begin
         drive_valid = 1'b0;
         burst_left = 8;
         gap_left = 0;
      end else if (!req_ch.valid || item_taken) begin
         drive_valid = 1'b0;
         if (drain_points.size() != 0 && chars_sent == drain_points[0]) begin
            if (expected_results.size() == 0)
               drain_points.pop_front();
         end else if (gap_left != 0) begin
            gap_left--;
         end else if (pending_chars.size() != 0) begin
            drive_valid = 1'b1;
            drive_char = pending_chars.pop_front();
            chars_sent++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_ch.valid <= drive_valid;
      req_ch.data.char_code <= drive_char;
   end

   // Result receiver: ready follows a rotating mask that is redrawn now and then.
   always @(negedge clock) begin : receiver
      int         stall_timer;
      logic [7:0] stall_mask;
      logic [2:0] stall_pos;
      // The mask position starts from a known value while reset is held.
      if (reset)
         stall_pos = 3'd0;
      if (stall_timer <= 0) begin
         stall_timer = $urandom_range(20, 80);
         stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      end else begin
         stall_timer--;
      end
      stall_pos = stall_pos + 3'd1;
      rsp_ch.ready <= stall_mask[stall_pos];
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      int directed_len;
      bit mid_marked;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      mid_marked = 1'b0;

      // Directed strings: empty, range limits, too many digits, signs and junk.
      add_text("");
      add_text("-2147483648");
      add_text("2147483647");
      add_text("+2147483648");
      add_text("-2147483649");
      add_text("12345678901");
      foreach (blank_codes[i])
         pending_chars.push_back(blank_codes[i]);
      add_text("+7");
      add_text("-");
      add_text("+-5");
      add_text("12-3");
      add_text("9x9");
      add_text("- 5");
      pending_chars.push_back(8'hFF);
      add_text("5");
      directed_len = pending_chars.size();
      drain_points.push_back(directed_len);

      // Random strings, with one more full drain about halfway through.
      while (pending_chars.size() < directed_len + RANDOM_CHARS) begin
         add_random_string();
         if (!mid_marked && pending_chars.size() >= directed_len + RANDOM_CHARS / 2) begin
            drain_points.push_back(pending_chars.size());
            mid_marked = 1'b1;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
